[hdl/segregated_free_list_block_allocator_defines.svh]
// ---------------------------------------------------------------------------
// Segregated free-list block allocator: assertion macros
// Concurrent check helpers. They sample on clk and are disabled while rst_n
// is low, so they expect both names in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef SEGREGATED_FREE_LIST_BLOCK_ALLOCATOR_DEFINES_SVH
`define SEGREGATED_FREE_LIST_BLOCK_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFLA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFLA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sfla_pkg.sv]
// ---------------------------------------------------------------------------
// Segregated free-list block allocator: shared definitions
// Widths, request and status codes, controller states and the carve
// descriptor used by the allocator.
// ---------------------------------------------------------------------------
package sfla_pkg;

  localparam int OFS_W           = 20;
  localparam int LINK_W          = OFS_W + 1;
  localparam int CLS_W           = 4;
  localparam int CLUSTER_BYTES   = 4096;
  localparam int MIN_BLOCK_BYTES = 16;
  localparam int MAX_CLUSTERS    = 256;
  localparam int CLUSTER_SHIFT   = $clog2(CLUSTER_BYTES);
  localparam int GRAN_SHIFT      = $clog2(MIN_BLOCK_BYTES);
  localparam int LINK_AW         = OFS_W - GRAN_SHIFT;
  localparam int LINK_DEPTH      = 1 << LINK_AW;
  localparam int ADDR_CLUSTERS   = (1 << OFS_W) / CLUSTER_BYTES;
  localparam int SZ_W            = CLUSTER_SHIFT + 1;
  localparam int USED_W          = OFS_W + 1;
  localparam int LIM_W           = 9;
  localparam int NUM_HEADS       = 8;
  localparam int HIDX_W          = $clog2(NUM_HEADS);
  localparam int SEC_W           = 3;

  localparam logic [CLS_W-1:0] CLUSTER_CLASS       = 4'd9;
  localparam logic [LIM_W-1:0] CLUSTER_LIMIT_RESET = 9'd256;
  localparam logic [SEC_W-1:0] FMT_LAST_SEC        = 3'd4;

  typedef logic [LINK_W-1:0] link_t;

  // Bit 20 of a link or a list head marks the list as empty.
  localparam link_t EMPTY_LINK = {1'b1, {OFS_W{1'b0}}};

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_FORMAT = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_LINK  = 4'b0100,
    S_CARVE = 4'b1000
  } state_t;

  // One run of blocks being linked, one link write per cycle.
  typedef struct packed {
    logic [OFS_W-1:0]  at;
    logic [SZ_W-1:0]   ofs;
    logic [SZ_W-1:0]   stop;
    logic [SZ_W-1:0]   sz;
    logic [HIDX_W-1:0] hidx;
    link_t             tail;
    link_t             head;
    logic              fmt;
    logic [SEC_W-1:0]  sec;
  } carve_t;

  function automatic logic [SZ_W-1:0] block_bytes(input logic [CLS_W-1:0] cls);
    return SZ_W'(8) << cls;
  endfunction

  function automatic logic [SZ_W-1:0] fmt_begin(input logic [SEC_W-1:0] sec);
    logic [SZ_W-1:0] b;
    case (sec)
      3'd0:    b = SZ_W'(256);
      3'd1:    b = SZ_W'(512);
      3'd2:    b = SZ_W'(1024);
      3'd3:    b = SZ_W'(2048);
      default: b = SZ_W'(3072);
    endcase
    return b;
  endfunction

  function automatic logic [SZ_W-1:0] fmt_end(input logic [SEC_W-1:0] sec);
    logic [SZ_W-1:0] e;
    case (sec)
      3'd0:    e = SZ_W'(512);
      3'd1:    e = SZ_W'(1024);
      3'd2:    e = SZ_W'(2048);
      3'd3:    e = SZ_W'(3072);
      default: e = SZ_W'(4096);
    endcase
    return e;
  endfunction

endpackage

[hdl/segregated_free_list_block_allocator.sv]
// ---------------------------------------------------------------------------
// Segregated free-list block allocator: free and rejected requests finish in S_EXEC;
// a list pop or a free-list cluster grant reads the link memory in S_EXEC and finishes in
// S_LINK; a refill writes 4096/size links in S_CARVE; format carves five sections there.
// A new beat is taken in the cycle the result strobe is high. Reset empties all lists,
// sets used space to one cluster and the limit to 256; link memory is not cleared.
// ---------------------------------------------------------------------------
`include "segregated_free_list_block_allocator_defines.svh"

module segregated_free_list_block_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_size_class,
  input  logic [19:0] in_block_offset,
  output logic        out_strobe,
  output logic [19:0] out_granted_offset,
  output logic [1:0]  out_status,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data
);

  localparam int OFS_W  = sfla_pkg::OFS_W;
  localparam int SZ_W   = sfla_pkg::SZ_W;
  localparam int HIDX_W = sfla_pkg::HIDX_W;
  localparam int GS     = sfla_pkg::GRAN_SHIFT;
  localparam int CS     = sfla_pkg::CLUSTER_SHIFT;
  localparam int USED_W = sfla_pkg::USED_W;
  localparam int LIM_W  = sfla_pkg::LIM_W;

  sfla_pkg::state_t state_r, state_nxt;

  logic [1:0]                  req_r;
  logic [sfla_pkg::CLS_W-1:0]  cls_r;
  logic [OFS_W-1:0]            ofs_r;
  logic [LIM_W-1:0]            cluster_limit_r;

  sfla_pkg::link_t heads_r [sfla_pkg::NUM_HEADS];
  sfla_pkg::link_t cfh_r, cfh_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [OFS_W-1:0]  tgt_r, tgt_nxt;
  logic              pop_r, pop_nxt;
  sfla_pkg::carve_t  cv_r, cv_nxt;

  logic                 head_we;
  logic [HIDX_W-1:0]    head_wa;
  sfla_pkg::link_t      head_wd;
  logic                 heads_clr;

  sfla_pkg::link_t          link_mem [sfla_pkg::LINK_DEPTH];
  sfla_pkg::link_t          mem_q;
  logic                     mem_we;
  logic [sfla_pkg::LINK_AW-1:0] mem_wa, mem_ra;
  sfla_pkg::link_t          mem_wd;

  logic                 done;
  logic [OFS_W-1:0]     done_grant;
  sfla_pkg::status_t    done_status;

  logic                 out_strobe_r;
  logic [OFS_W-1:0]     out_grant_r;
  logic [1:0]           out_status_r;

  logic                 cls_ok, is_cluster, misaligned, bump_fail;
  logic [HIDX_W-1:0]    hidx;
  sfla_pkg::link_t      cur_head;
  logic [SZ_W-1:0]      blk_sz;
  logic [CS-1:0]        align_mask;
  logic [LIM_W-1:0]     lim;
  logic [USED_W:0]      bump_end, bump_cap;
  logic [SZ_W-1:0]      step_ofs;
  logic [OFS_W-1:0]     next_at;
  logic                 carve_last;

  function automatic sfla_pkg::carve_t carve_alloc(input logic [OFS_W-1:0] base,
                                                   input logic [SZ_W-1:0] sz,
                                                   input logic [HIDX_W-1:0] hi,
                                                   input sfla_pkg::link_t tail);
    sfla_pkg::carve_t c;
    c.at   = base;
    c.ofs  = '0;
    c.stop = SZ_W'(sfla_pkg::CLUSTER_BYTES);
    c.sz   = sz;
    c.hidx = hi;
    c.tail = tail;
    c.head = {1'b0, base + OFS_W'(sz)};
    c.fmt  = 1'b0;
    c.sec  = '0;
    return c;
  endfunction

  // Format sections go to classes 1 to 5 in turn, so the head index is the section.
  function automatic sfla_pkg::carve_t carve_format(input logic [sfla_pkg::SEC_W-1:0] sec);
    sfla_pkg::carve_t c;
    c.at   = OFS_W'(sfla_pkg::fmt_begin(sec));
    c.ofs  = sfla_pkg::fmt_begin(sec);
    c.stop = sfla_pkg::fmt_end(sec);
    c.sz   = sfla_pkg::block_bytes(sfla_pkg::CLS_W'(sec) + 4'd1);
    c.hidx = HIDX_W'(sec);
    c.tail = sfla_pkg::EMPTY_LINK;
    c.head = {1'b0, OFS_W'(sfla_pkg::fmt_begin(sec))};
    c.fmt  = 1'b1;
    c.sec  = sec;
    return c;
  endfunction

  assign busy               = (state_r != sfla_pkg::S_IDLE);
  assign out_strobe         = out_strobe_r;
  assign out_granted_offset = out_grant_r;
  assign out_status         = out_status_r;

  // Request decode on the captured beat.
  assign cls_ok     = (cls_r >= 4'd1) && (cls_r <= sfla_pkg::CLUSTER_CLASS);
  assign is_cluster = (cls_r == sfla_pkg::CLUSTER_CLASS);
  assign hidx       = HIDX_W'(cls_r - 4'd1);
  assign cur_head   = heads_r[hidx];
  assign blk_sz     = sfla_pkg::block_bytes(cls_r);
  assign align_mask = CS'(blk_sz - SZ_W'(1));
  assign misaligned = (ofs_r[CS-1:0] & align_mask) != '0;

  always_comb begin
    lim = cluster_limit_r;
    if ((sfla_pkg::MAX_CLUSTERS < sfla_pkg::ADDR_CLUSTERS) &&
        (cluster_limit_r > sfla_pkg::MAX_CLUSTERS)) begin
      lim = LIM_W'(sfla_pkg::MAX_CLUSTERS);
    end
    if (lim > sfla_pkg::ADDR_CLUSTERS) begin
      lim = LIM_W'(sfla_pkg::ADDR_CLUSTERS);
    end
  end

  assign bump_end  = {1'b0, used_r} + (USED_W+1)'(sfla_pkg::CLUSTER_BYTES);
  assign bump_cap  = (USED_W+1)'({lim, CS'(0)});
  assign bump_fail = bump_end > bump_cap;

  assign step_ofs   = cv_r.ofs + cv_r.sz;
  assign next_at    = cv_r.at + OFS_W'(cv_r.sz);
  assign carve_last = (step_ofs == cv_r.stop);

  always_comb begin
    state_nxt   = state_r;
    cfh_nxt     = cfh_r;
    used_nxt    = used_r;
    tgt_nxt     = tgt_r;
    pop_nxt     = pop_r;
    cv_nxt      = cv_r;
    head_we     = 1'b0;
    head_wa     = hidx;
    head_wd     = mem_q;
    heads_clr   = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = ofs_r[OFS_W-1:GS];
    mem_wd      = cur_head;
    mem_ra      = cur_head[OFS_W-1:GS];
    done        = 1'b0;
    done_grant  = '0;
    done_status = sfla_pkg::ST_OK;

    unique case (state_r)
      sfla_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = sfla_pkg::S_EXEC;
        end
      end

      sfla_pkg::S_EXEC: begin
        unique case (req_r)
          sfla_pkg::REQ_ALLOC: begin
            if (!cls_ok) begin
              done        = 1'b1;
              done_status = sfla_pkg::ST_BAD;
            end else if (is_cluster && !cfh_r[OFS_W]) begin
              mem_ra    = cfh_r[OFS_W-1:GS];
              tgt_nxt   = cfh_r[OFS_W-1:0];
              pop_nxt   = 1'b0;
              state_nxt = sfla_pkg::S_LINK;
            end else if (!is_cluster && !cur_head[OFS_W]) begin
              mem_ra    = cur_head[OFS_W-1:GS];
              tgt_nxt   = cur_head[OFS_W-1:0];
              pop_nxt   = 1'b1;
              state_nxt = sfla_pkg::S_LINK;
            end else if (!is_cluster && !cfh_r[OFS_W]) begin
              mem_ra    = cfh_r[OFS_W-1:GS];
              tgt_nxt   = cfh_r[OFS_W-1:0];
              pop_nxt   = 1'b0;
              state_nxt = sfla_pkg::S_LINK;
            end else if (bump_fail) begin
              done        = 1'b1;
              done_status = sfla_pkg::ST_NO_SPACE;
            end else begin
              used_nxt = used_r + USED_W'(sfla_pkg::CLUSTER_BYTES);
              if (is_cluster) begin
                done       = 1'b1;
                done_grant = used_r[OFS_W-1:0];
              end else begin
                tgt_nxt   = used_r[OFS_W-1:0];
                cv_nxt    = carve_alloc(used_r[OFS_W-1:0], blk_sz, hidx, cur_head);
                state_nxt = sfla_pkg::S_CARVE;
              end
            end
          end

          sfla_pkg::REQ_FREE: begin
            done = 1'b1;
            if (!cls_ok || misaligned) begin
              done_status = sfla_pkg::ST_BAD;
            end else if (is_cluster) begin
              mem_we  = 1'b1;
              mem_wd  = cfh_r;
              cfh_nxt = {1'b0, ofs_r};
            end else begin
              mem_we  = 1'b1;
              head_we = 1'b1;
              head_wd = {1'b0, ofs_r};
            end
          end

          sfla_pkg::REQ_FORMAT: begin
            heads_clr = 1'b1;
            cfh_nxt   = sfla_pkg::EMPTY_LINK;
            used_nxt  = USED_W'(sfla_pkg::CLUSTER_BYTES);
            cv_nxt    = carve_format('0);
            state_nxt = sfla_pkg::S_CARVE;
          end

          default: begin
            done        = 1'b1;
            done_status = sfla_pkg::ST_BAD;
          end
        endcase
      end

      // The link read issued in the execute cycle is on mem_q now.
      sfla_pkg::S_LINK: begin
        if (is_cluster) begin
          cfh_nxt    = mem_q;
          done       = 1'b1;
          done_grant = tgt_r;
        end else if (pop_r) begin
          head_we    = 1'b1;
          done       = 1'b1;
          done_grant = tgt_r;
        end else begin
          cfh_nxt   = mem_q;
          cv_nxt    = carve_alloc(tgt_r, blk_sz, hidx, cur_head);
          state_nxt = sfla_pkg::S_CARVE;
        end
      end

      // Blocks are linked in ascending order; the last one points at the old head.
      sfla_pkg::S_CARVE: begin
        mem_we     = 1'b1;
        mem_wa     = cv_r.at[OFS_W-1:GS];
        mem_wd     = carve_last ? cv_r.tail : {1'b0, next_at};
        cv_nxt.at  = next_at;
        cv_nxt.ofs = step_ofs;
        if (carve_last) begin
          head_we = 1'b1;
          head_wa = cv_r.hidx;
          head_wd = cv_r.head;
          if (cv_r.fmt && (cv_r.sec != sfla_pkg::FMT_LAST_SEC)) begin
            cv_nxt = carve_format(cv_r.sec + 3'd1);
          end else begin
            done       = 1'b1;
            done_grant = cv_r.fmt ? '0 : tgt_r;
          end
        end
      end

      default: begin
        state_nxt = sfla_pkg::S_IDLE;
      end
    endcase

    if (done) begin
      state_nxt = sfla_pkg::S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= sfla_pkg::S_IDLE;
      cluster_limit_r <= sfla_pkg::CLUSTER_LIMIT_RESET;
      cfh_r           <= sfla_pkg::EMPTY_LINK;
      used_r          <= USED_W'(sfla_pkg::CLUSTER_BYTES);
      out_strobe_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cfh_r        <= cfh_nxt;
      used_r       <= used_nxt;
      out_strobe_r <= done;
      if (cfg_wr_en) begin
        cluster_limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sfla_pkg::NUM_HEADS; i++) begin
        heads_r[i] <= sfla_pkg::EMPTY_LINK;
      end
    end else if (heads_clr) begin
      for (int i = 0; i < sfla_pkg::NUM_HEADS; i++) begin
        heads_r[i] <= sfla_pkg::EMPTY_LINK;
      end
    end else if (head_we) begin
      heads_r[head_wa] <= head_wd;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == sfla_pkg::S_IDLE) && start) begin
      req_r <= in_req_type;
      cls_r <= in_size_class;
      ofs_r <= in_block_offset;
    end
    tgt_r <= tgt_nxt;
    pop_r <= pop_nxt;
    cv_r  <= cv_nxt;
    if (done) begin
      out_grant_r  <= done_grant;
      out_status_r <= done_status;
    end
  end

  // Link words, one per 16-byte granule.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    mem_q <= link_mem[mem_ra];
  end

  `SFLA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted beat did not start work")
  `SFLA_ASSERT_IMP(a_result_idle, out_strobe, !busy, "result shown while still busy")
  `SFLA_ASSERT_IMP(a_carve_range, state_r == sfla_pkg::S_CARVE, cv_r.ofs < cv_r.stop, "carve past run end")

endmodule

[test/segregated_free_list_block_allocator_checker.sv]
// ---------------------------------------------------------------------------
// Block allocator checker
// Watches the request, result and configuration ports of the allocator. It
// keeps its own copy of the free lists, the bump pointer and the link words.
// From these it works out the grant and status of every accepted request,
// and compares each result beat against the oldest one still due.
// ---------------------------------------------------------------------------
module segregated_free_list_block_allocator_checker
  import sfla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_req_type,
  input  logic [CLS_W-1:0]  in_size_class,
  input  logic [OFS_W-1:0]  in_block_offset,
  input  logic              out_strobe,
  input  logic [OFS_W-1:0]  out_granted_offset,
  input  logic [1:0]        out_status,
  input  logic              cfg_wr_en,
  input  logic [LIM_W-1:0]  cfg_wr_data,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [OFS_W-1:0] grant;
    status_t          status;
  } alloc_result_t;

  logic [LIM_W-1:0]  limit_reg;
  logic [LINK_W-1:0] list_head [NUM_HEADS + 1];
  logic [LINK_W-1:0] cluster_head;
  logic [USED_W-1:0] bump_bytes;
  bit   [LINK_W-1:0] link_mem [LINK_DEPTH];

  alloc_result_t due_results [$];
  alloc_result_t want;

  // Takes a cluster from the free-cluster list, or else from the bump pointer
  // as long as one more cluster stays inside the effective limit.
  function automatic bit grab_cluster(output logic [OFS_W-1:0] got);
    int unsigned cap;
    got = '0;
    if (!cluster_head[OFS_W]) begin
      got = cluster_head[OFS_W-1:0];
      cluster_head = link_mem[got[OFS_W-1:GRAN_SHIFT]];
      return 1'b1;
    end
    cap = limit_reg;
    if (cap > MAX_CLUSTERS) cap = MAX_CLUSTERS;
    if (cap > ADDR_CLUSTERS) cap = ADDR_CLUSTERS;
    if (bump_bytes + CLUSTER_BYTES > cap * CLUSTER_BYTES) return 1'b0;
    got = bump_bytes[OFS_W-1:0];
    bump_bytes = bump_bytes + CLUSTER_BYTES;
    return 1'b1;
  endfunction

  // Links the blocks of one class lying in [base+lo, base+hi) in ascending
  // order, the last one pointing at the old head of the list.
  function automatic void link_run(input logic [CLS_W-1:0] cls, input logic [OFS_W-1:0] base,
                                   input int unsigned lo, input int unsigned hi);
    int unsigned      sz;
    int unsigned      pos;
    logic [LINK_W-1:0] head;
    logic [OFS_W-1:0] at;
    sz = 8 << cls;
    head = list_head[cls - 1];
    pos = hi;
    while (pos >= lo + sz) begin
      pos = pos - sz;
      at = base + OFS_W'(pos);
      link_mem[at[OFS_W-1:GRAN_SHIFT]] = head;
      head = {1'b0, at};
    end
    list_head[cls - 1] = head;
  endfunction

  function automatic alloc_result_t serve_request(input logic [1:0] req,
                                                  input logic [CLS_W-1:0] cls,
                                                  input logic [OFS_W-1:0] ofs);
    alloc_result_t     res;
    logic [LINK_W-1:0] head;
    logic [OFS_W-1:0]  got;
    int unsigned       bytes;
    res.grant = '0;
    res.status = ST_OK;
    bytes = 8 << cls;
    case (req)
      REQ_ALLOC: begin
        if (cls == '0 || cls > CLUSTER_CLASS) begin
          res.status = ST_BAD;
        end else if (cls == CLUSTER_CLASS) begin
          if (grab_cluster(got)) res.grant = got;
          else res.status = ST_NO_SPACE;
        end else begin
          if (list_head[cls - 1][OFS_W]) begin
            if (grab_cluster(got)) link_run(cls, got, 0, CLUSTER_BYTES);
            else res.status = ST_NO_SPACE;
          end
          if (res.status == ST_OK) begin
            head = list_head[cls - 1];
            res.grant = head[OFS_W-1:0];
            list_head[cls - 1] = link_mem[res.grant[OFS_W-1:GRAN_SHIFT]];
          end
        end
      end
      REQ_FREE: begin
        if (cls == '0 || cls > CLUSTER_CLASS) begin
          res.status = ST_BAD;
        end else if ((ofs & (bytes - 1)) != 0) begin
          res.status = ST_BAD;
        end else if (cls == CLUSTER_CLASS) begin
          link_mem[ofs[OFS_W-1:GRAN_SHIFT]] = cluster_head;
          cluster_head = {1'b0, ofs};
        end else begin
          link_mem[ofs[OFS_W-1:GRAN_SHIFT]] = list_head[cls - 1];
          list_head[cls - 1] = {1'b0, ofs};
        end
      end
      REQ_FORMAT: begin
        for (int i = 0; i <= NUM_HEADS; i++) list_head[i] = EMPTY_LINK;
        cluster_head = EMPTY_LINK;
        // Cluster 0 is split into fixed sections for the five smallest classes.
        link_run(4'd1, '0, 256, 512);
        link_run(4'd2, '0, 512, 1024);
        link_run(4'd3, '0, 1024, 2048);
        link_run(4'd4, '0, 2048, 3072);
        link_run(4'd5, '0, 3072, 4096);
        bump_bytes = CLUSTER_BYTES;
      end
      default: res.status = ST_BAD;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      limit_reg = CLUSTER_LIMIT_RESET;
      for (int i = 0; i <= NUM_HEADS; i++) list_head[i] = EMPTY_LINK;
      cluster_head = EMPTY_LINK;
      bump_bytes = CLUSTER_BYTES;
      due_results.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (cfg_wr_en) limit_reg = cfg_wr_data;
      if (out_strobe) begin
        if (due_results.size() == 0) begin
          fail_count = fail_count + 1;
          $display("%0t: result beat with nothing due: grant %h status %0d",
                   $time, out_granted_offset, out_status);
        end else begin
          want = due_results.pop_front();
          if (out_granted_offset !== want.grant) begin
            fail_count = fail_count + 1;
            $display("%0t: granted_offset mismatch: expected %h, actual %h",
                     $time, want.grant, out_granted_offset);
          end
          if (out_status !== want.status) begin
            fail_count = fail_count + 1;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_status);
          end
        end
      end
      if (start && !busy)
        due_results.push_back(serve_request(in_req_type, in_size_class, in_block_offset));
      pending = due_results.size();
    end
  end

endmodule

[test/segregated_free_list_block_allocator_test.sv]
// ---------------------------------------------------------------------------
// Block allocator testbench
// Drives allocate, free and format requests into the allocator across
// several cluster limits and sender idle rates. Frees mostly return blocks
// that were granted earlier; the rest are broken or random requests. The
// checker next to the block predicts and compares every result.
// ---------------------------------------------------------------------------
module segregated_free_list_block_allocator_test;
  import sfla_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 2_000_000;
  localparam int          ITEMS_PER_PHASE = 305;
  localparam int          NUM_PHASES      = 6;
  localparam int          SETTLE_CYCLES   = 300;

  localparam logic [1:0]       REQ_UNKNOWN = 2'd3;
  localparam logic [CLS_W-1:0] CLASS_NONE  = 4'd0;
  localparam logic [CLS_W-1:0] CLASS_TOP   = 4'd15;

  typedef struct packed {
    logic [1:0]       req;
    logic [CLS_W-1:0] cls;
  } issued_t;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [OFS_W-1:0] ofs;
  } block_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_req_type;
  logic [CLS_W-1:0]  in_size_class;
  logic [OFS_W-1:0]  in_block_offset;
  logic              out_strobe;
  logic [OFS_W-1:0]  out_granted_offset;
  logic [1:0]        out_status;
  logic              cfg_wr_en;
  logic [LIM_W-1:0]  cfg_wr_data;

  int          fail_count;
  int          pending;
  int unsigned cycle_count;
  int          idle_pct;

  issued_t issued_reqs [$];
  block_t  live_blocks [$];
  issued_t seen_req;

  segregated_free_list_block_allocator u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_size_class      (in_size_class),
    .in_block_offset    (in_block_offset),
    .out_strobe         (out_strobe),
    .out_granted_offset (out_granted_offset),
    .out_status         (out_status),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  segregated_free_list_block_allocator_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_size_class      (in_size_class),
    .in_block_offset    (in_block_offset),
    .out_strobe         (out_strobe),
    .out_granted_offset (out_granted_offset),
    .out_status         (out_status),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Granted blocks are collected so that later frees hand back real blocks.
  // A format invalidates everything handed out before it.
  always @(posedge clk) begin
    if (rst_n && out_strobe && issued_reqs.size() > 0) begin
      seen_req = issued_reqs.pop_front();
      if (seen_req.req == REQ_FORMAT)
        live_blocks.delete();
      else if (seen_req.req == REQ_ALLOC && out_status == ST_OK)
        live_blocks.push_back({seen_req.cls, out_granted_offset});
    end
  end

  task automatic issue(input logic [1:0] rt, input logic [CLS_W-1:0] cls,
                       input logic [OFS_W-1:0] ofs);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_req_type <= rt;
    in_size_class <= cls;
    in_block_offset <= ofs;
    @(posedge clk);
    while (busy) @(posedge clk);
    issued_reqs.push_back({rt, cls});
  endtask

  // Holds the sender off until every result beat has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_item();
    int               pick;
    int               slot;
    block_t           blk;
    logic [1:0]       rt;
    logic [CLS_W-1:0] cls;
    logic [OFS_W-1:0] ofs;
    pick = $urandom_range(99);
    if (pick < 40 || (pick < 75 && live_blocks.size() == 0)) begin
      cls = CLS_W'($urandom_range(1, 9));
      if ($urandom_range(49) == 0) cls = $urandom_range(1) ? CLASS_NONE
                                                         : CLS_W'($urandom_range(10, 15));
      issue(REQ_ALLOC, cls, OFS_W'($urandom()));
    end else if (pick < 75) begin
      slot = $urandom_range(live_blocks.size() - 1);
      blk = live_blocks[slot];
      live_blocks.delete(slot);
      issue(REQ_FREE, blk.cls, blk.ofs);
    end else if (pick < 76) begin
      issue(REQ_FORMAT, CLS_W'($urandom()), OFS_W'($urandom()));
    end else begin
      case ($urandom_range(2))
        0:       rt = REQ_ALLOC;
        1:       rt = REQ_FREE;
        default: rt = REQ_UNKNOWN;
      endcase
      cls = CLS_W'($urandom());
      ofs = OFS_W'($urandom());
      if (cls != CLASS_NONE && cls <= CLUSTER_CLASS && $urandom_range(1))
        ofs = ofs & ~((OFS_W'(8) << cls) - OFS_W'(1));
      issue(rt, cls, ofs);
    end
    if ($urandom_range(199) == 0) drain();
  endtask

  initial begin
    start = 1'b0;
    in_req_type = REQ_ALLOC;
    in_size_class = '0;
    in_block_offset = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    idle_pct = 0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every class once; classes 1 to 8 each refill from a fresh cluster, class 9 takes one whole.
    for (int c = 1; c <= 9; c++) issue(REQ_ALLOC, CLS_W'(c), '0);
    // Blocks at the top of the address space go round the lists.
    issue(REQ_FREE, CLUSTER_CLASS, 20'hFF000);
    issue(REQ_FREE, 4'd1, 20'hFFFF0);
    issue(REQ_ALLOC, CLUSTER_CLASS, 20'hFFFFF);
    issue(REQ_ALLOC, 4'd1, '0);
    issue(REQ_FREE, 4'd8, 20'h00010);
    issue(REQ_ALLOC, CLASS_NONE, '0);
    issue(REQ_FREE, CLASS_TOP, '0);
    issue(REQ_UNKNOWN, 4'd1, '0);
    issue(REQ_FORMAT, CLASS_TOP, 20'hFFFFF);
    issue(REQ_ALLOC, 4'd1, '0);
    issue(REQ_ALLOC, 4'd5, '0);
    // With a zero limit only a freed cluster can be handed out.
    drain();
    write_limit('0);
    issue(REQ_ALLOC, CLUSTER_CLASS, '0);
    issue(REQ_ALLOC, 4'd6, '0);
    issue(REQ_FREE, CLUSTER_CLASS, 20'h01000);
    issue(REQ_ALLOC, 4'd8, '0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin write_limit(9'd511); idle_pct = 0; end
        1: begin write_limit(9'd2); idle_pct = 86; end
        2: begin write_limit(9'd256); idle_pct = 16; end
        3: begin write_limit(9'd1); idle_pct = 86; end
        4: begin write_limit(LIM_W'($urandom_range(3, 40))); idle_pct = 0; end
        default: begin write_limit(9'd256); idle_pct = 16; end
      endcase
      repeat (ITEMS_PER_PHASE) random_item();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/sfla_pkg.sv
hdl/segregated_free_list_block_allocator.sv
test/segregated_free_list_block_allocator_checker.sv
test/segregated_free_list_block_allocator_test.sv
